// File: rtl/prs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_pkg: shared types and constants of the rail request sequencer
// Request/response structs, register map, command codes and status codes.
// ----------------------------------------------------------------------------
package prs_pkg;

   // Request type codes
   localparam logic [2:0] REQ_SET_VOLT   = 3'd0;
   localparam logic [2:0] REQ_GET_VOLT   = 3'd1;
   localparam logic [2:0] REQ_SET_ENABLE = 3'd2;
   localparam logic [2:0] REQ_I2C_DONE   = 3'd3;
   localparam logic [2:0] REQ_ALARM_DONE = 3'd4;

   // Response kinds
   localparam logic [2:0] KIND_REPLY      = 3'd0;
   localparam logic [2:0] KIND_I2C_WRITE  = 3'd1;
   localparam logic [2:0] KIND_I2C_WR_RD  = 3'd2;
   localparam logic [2:0] KIND_ALARM      = 3'd3;
   localparam logic [2:0] KIND_FINAL      = 3'd4;

   // Status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_PENDING = 3'd1;
   localparam logic [2:0] ST_BUSY    = 3'd2;
   localparam logic [2:0] ST_RANGE   = 3'd3;
   localparam logic [2:0] ST_DEVERR  = 3'd4;
   localparam logic [2:0] ST_UNEXP   = 3'd5;

   // I2C command codes and transfer lengths
   localparam logic [7:0] CMD_GET_V  = 8'h10;
   localparam logic [7:0] CMD_ENABLE = 8'h1E;
   localparam logic [7:0] CMD_SET_V  = 8'h20;
   localparam logic [1:0] LEN_NONE   = 2'd0;
   localparam logic [1:0] LEN_ONE    = 2'd1;
   localparam logic [1:0] LEN_TWO    = 2'd2;
   localparam logic [1:0] LEN_THREE  = 2'd3;

   // Register map: register i at byte address 4*i
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] CSR_CHANNEL    = 3'd0;
   localparam logic [2:0] CSR_MAX_TARGET = 3'd1;
   localparam logic [2:0] CSR_MARGIN     = 3'd2;
   localparam logic [2:0] CSR_RAMP_SET   = 3'd3;
   localparam logic [2:0] CSR_RAMP_EN    = 3'd4;

   // Register reset values
   localparam logic [1:0]  RST_CHANNEL    = 2'd0;
   localparam logic [15:0] RST_MAX_TARGET = 16'd1100;
   localparam logic [7:0]  RST_MARGIN     = 8'd20;
   localparam logic [7:0]  RST_RAMP_SET   = 8'd1;
   localparam logic [7:0]  RST_RAMP_EN    = 8'd2;

   // Read-back scale: millivolts per received count
   localparam logic [3:0] READ_SCALE = 4'd15;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [15:0] target_mv;
      logic        enable_value;
      logic        i2c_ok;
      logic [15:0] read_word;
      logic        adc_ok;
      logic [15:0] adc_mv;
   } prs_req_type;

   typedef struct packed {
      logic [2:0]  out_kind;
      logic [2:0]  status;
      logic [19:0] voltage_mv;
      logic        rail_enabled;
      logic [7:0]  cmd_byte0;
      logic [7:0]  cmd_byte1;
      logic [7:0]  cmd_byte2;
      logic [1:0]  write_len;
      logic [1:0]  read_len;
      logic [7:0]  alarm_ms;
   } prs_rsp_type;

   typedef struct packed {
      logic [1:0]  channel_index;
      logic [15:0] max_target_mv;
      logic [7:0]  margin_mv;
      logic [7:0]  ramp_set_ms;
      logic [7:0]  ramp_enable_ms;
   } prs_cfg_type;

endpackage

// File: rtl/psu_rail_request_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_rail_request_sequencer_unit: supply rail request sequencer
// Turns voltage/enable requests and bus/alarm events into bus commands,
// alarms and final responses for one rail.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+----------------------
//  request   | in        | req_valid / req_ready     | req_data (prs_req_type)
//  response  | out       | rsp_valid / rsp_ready     | rsp_data (prs_rsp_type)
//  settings  | in        | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
//  One request per cycle sustained while the output drains. A request passes
//  through the input register, then the single decision stage, then the
//  response register before it is answered. Synchronous reset puts the rail
//  in idle, enabled, with an unknown cached voltage. A stalled response holds
//  the input register; one more request can still be taken while the slot
//  is full.
// ----------------------------------------------------------------------------
module psu_rail_request_sequencer_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  prs_pkg::prs_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output prs_pkg::prs_rsp_type            rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [prs_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import prs_pkg::*;

   prs_cfg_type cfg;

   prs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   prs_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/prs_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_csr: configuration register file
// APB-style write/read access to the five sequencer settings.
// ----------------------------------------------------------------------------
module prs_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [prs_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready,
   output prs_pkg::prs_cfg_type             cfg
);
   import prs_pkg::*;

   prs_cfg_type cfg_ff;
   logic [2:0]  index;
   logic        wr_en;

   assign index  = paddr[CSR_ADDR_W-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // register writes in the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_index  <= RST_CHANNEL;
         cfg_ff.max_target_mv  <= RST_MAX_TARGET;
         cfg_ff.margin_mv      <= RST_MARGIN;
         cfg_ff.ramp_set_ms    <= RST_RAMP_SET;
         cfg_ff.ramp_enable_ms <= RST_RAMP_EN;
      end else if (wr_en) begin
         unique case (index)
            CSR_CHANNEL:    cfg_ff.channel_index  <= pwdata[1:0];
            CSR_MAX_TARGET: cfg_ff.max_target_mv  <= pwdata[15:0];
            CSR_MARGIN:     cfg_ff.margin_mv      <= pwdata[7:0];
            CSR_RAMP_SET:   cfg_ff.ramp_set_ms    <= pwdata[7:0];
            CSR_RAMP_EN:    cfg_ff.ramp_enable_ms <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // read-back mux
   always_comb begin
      unique case (index)
         CSR_CHANNEL:    prdata = {30'd0, cfg_ff.channel_index};
         CSR_MAX_TARGET: prdata = {16'd0, cfg_ff.max_target_mv};
         CSR_MARGIN:     prdata = {24'd0, cfg_ff.margin_mv};
         CSR_RAMP_SET:   prdata = {24'd0, cfg_ff.ramp_set_ms};
         CSR_RAMP_EN:    prdata = {24'd0, cfg_ff.ramp_enable_ms};
         default:        prdata = 32'd0;
      endcase
   end

endmodule

// File: rtl/prs_vcode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_vcode: voltage target encoder
// Splits a millivolt target into 12.5 mV coarse steps and 2.5 mV fine steps.
// ----------------------------------------------------------------------------
module prs_vcode (
   input  logic [15:0] target_mv,
   output logic [15:0] vcode
);
   // coarse = floor(2*target / 25) through a reciprocal multiply
   localparam int          RECIP_SHIFT = 22;
   localparam logic [17:0] RECIP_MUL   = 18'((2**RECIP_SHIFT + 24) / 25);
   localparam logic [2:0]  FINE_MAX    = 3'h7;

   logic [16:0] twice;
   logic [34:0] prod;
   logic [12:0] coarse;
   logic [16:0] coarse_x25;
   logic [15:0] mvref;
   logic [15:0] diff;
   logic [2:0]  fine;

   // fine steps = floor(diff * 2 / 5), diff stays below 13
   function automatic logic [2:0] fine_steps(input logic [3:0] d);
      logic [2:0] f;
      case (d)
         4'd0, 4'd1, 4'd2:   f = 3'd0;
         4'd3, 4'd4:         f = 3'd1;
         4'd5, 4'd6, 4'd7:   f = 3'd2;
         4'd8, 4'd9:         f = 3'd3;
         4'd10, 4'd11, 4'd12: f = 3'd4;
         4'd13, 4'd14:       f = 3'd5;
         default:            f = 3'd6;
      endcase
      return f;
   endfunction

   always_comb begin
      twice      = {target_mv, 1'b0};
      prod       = 35'(twice) * 35'(RECIP_MUL);
      coarse     = prod[34:RECIP_SHIFT];
      // coarse * 12.5 mV, rounded down
      coarse_x25 = {coarse, 4'd0} + {1'b0, coarse, 3'd0} + {4'd0, coarse};
      mvref      = coarse_x25[16:1];
      diff       = target_mv - mvref;
      fine       = fine_steps(diff[3:0]);
      if (fine > FINE_MAX) begin
         fine = FINE_MAX;
      end
      // fine count sits at bit 12 and overlaps the top coarse bit
      vcode = {1'b0, fine, 12'd0} | {3'd0, coarse};
   end

endmodule

// File: rtl/prs_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_seq: request sequencer datapath and phase machine
// Input register, single-pass decision logic, rail state and response register.
// ----------------------------------------------------------------------------
module prs_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  prs_pkg::prs_cfg_type  cfg,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  prs_pkg::prs_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output prs_pkg::prs_rsp_type  rsp_data
);
   import prs_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_CONVERT,
      PH_WAIT_VOLT,
      PH_COMPARE,
      PH_WAIT_EN,
      PH_DONE_EN
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [19:0] cached_ff, cached_in;
   logic        enabled_ff, enabled_in;
   logic [15:0] pend_mv_ff, pend_mv_in;
   logic        pend_en_ff, pend_en_in;
   logic        in_valid_ff;
   prs_req_type in_data_ff;
   logic        out_valid_ff;
   prs_rsp_type out_data_ff, out_data_in;
   logic        advance;
   logic [15:0] vcode;
   logic [16:0] adc_plus;
   logic [16:0] tgt_plus;
   logic [19:0] read_mv;

   prs_vcode u_vcode (
      .target_mv (in_data_ff.target_mv),
      .vcode     (vcode)
   );

   // request moves on when the response slot is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign adc_plus = {1'b0, in_data_ff.adc_mv} + {9'd0, cfg.margin_mv};
   assign tgt_plus = {1'b0, pend_mv_ff} + {9'd0, cfg.margin_mv};
   assign read_mv  = 20'(in_data_ff.read_word) * 20'(READ_SCALE);

   // decision logic for the request in the input register
   always_comb begin
      phase_in   = phase_ff;
      cached_in  = cached_ff;
      enabled_in = enabled_ff;
      pend_mv_in = pend_mv_ff;
      pend_en_in = pend_en_ff;
      out_data_in = '0;
      out_data_in.out_kind = KIND_REPLY;
      out_data_in.status   = ST_UNEXP;

      case (in_data_ff.req_type)
         REQ_SET_VOLT: begin
            if (in_data_ff.target_mv > cfg.max_target_mv) begin
               out_data_in.status = ST_RANGE;
            end else if (phase_ff != PH_IDLE) begin
               out_data_in.status = ST_BUSY;
            end else if (cached_ff != 20'd0 && cached_ff == {4'd0, in_data_ff.target_mv}) begin
               out_data_in.status = ST_OK;
            end else begin
               pend_mv_in = in_data_ff.target_mv;
               phase_in   = PH_WAIT_VOLT;
               out_data_in.out_kind  = KIND_I2C_WRITE;
               out_data_in.status    = ST_PENDING;
               out_data_in.cmd_byte0 = CMD_SET_V + {6'd0, cfg.channel_index};
               out_data_in.cmd_byte1 = vcode[15:8];
               out_data_in.cmd_byte2 = vcode[7:0];
               out_data_in.write_len = LEN_THREE;
            end
         end
         REQ_GET_VOLT: begin
            if (phase_ff != PH_IDLE) begin
               out_data_in.status = ST_BUSY;
            end else if (cached_ff != 20'd0) begin
               out_data_in.status = ST_OK;
            end else begin
               phase_in = PH_CONVERT;
               out_data_in.out_kind  = KIND_I2C_WR_RD;
               out_data_in.status    = ST_PENDING;
               out_data_in.cmd_byte0 = CMD_GET_V + {6'd0, cfg.channel_index};
               out_data_in.write_len = LEN_ONE;
               out_data_in.read_len  = LEN_TWO;
            end
         end
         REQ_SET_ENABLE: begin
            if (phase_ff != PH_IDLE) begin
               out_data_in.status = ST_BUSY;
            end else begin
               pend_en_in = in_data_ff.enable_value;
               phase_in   = PH_WAIT_EN;
               out_data_in.out_kind  = KIND_I2C_WRITE;
               out_data_in.status    = ST_PENDING;
               out_data_in.cmd_byte0 = CMD_ENABLE;
               out_data_in.cmd_byte1 = {6'd0, cfg.channel_index};
               out_data_in.cmd_byte2 = {7'd0, in_data_ff.enable_value};
               out_data_in.write_len = LEN_THREE;
            end
         end
         REQ_I2C_DONE: begin
            if (phase_ff == PH_CONVERT) begin
               phase_in = PH_IDLE;
               out_data_in.out_kind = KIND_FINAL;
               if (in_data_ff.i2c_ok) begin
                  cached_in = read_mv;
                  out_data_in.status = ST_OK;
               end else begin
                  out_data_in.status = ST_DEVERR;
               end
            end else if (phase_ff == PH_WAIT_VOLT) begin
               if (!in_data_ff.i2c_ok) begin
                  phase_in = PH_IDLE;
                  out_data_in.out_kind = KIND_FINAL;
                  out_data_in.status   = ST_DEVERR;
               end else if (enabled_ff) begin
                  phase_in = PH_COMPARE;
                  out_data_in.out_kind = KIND_ALARM;
                  out_data_in.status   = ST_PENDING;
                  out_data_in.alarm_ms = cfg.ramp_set_ms;
               end else begin
                  cached_in = {4'd0, pend_mv_ff};
                  phase_in  = PH_IDLE;
                  out_data_in.out_kind = KIND_FINAL;
                  out_data_in.status   = ST_OK;
               end
            end else if (phase_ff == PH_WAIT_EN) begin
               if (!in_data_ff.i2c_ok) begin
                  phase_in = PH_IDLE;
                  out_data_in.out_kind = KIND_FINAL;
                  out_data_in.status   = ST_DEVERR;
               end else begin
                  enabled_in = pend_en_ff;
                  if (pend_en_ff) begin
                     phase_in = PH_DONE_EN;
                     out_data_in.out_kind = KIND_ALARM;
                     out_data_in.status   = ST_PENDING;
                     out_data_in.alarm_ms = cfg.ramp_enable_ms;
                  end else begin
                     phase_in = PH_IDLE;
                     out_data_in.out_kind = KIND_FINAL;
                     out_data_in.status   = ST_OK;
                  end
               end
            end
         end
         REQ_ALARM_DONE: begin
            if (phase_ff == PH_COMPARE) begin
               phase_in = PH_IDLE;
               out_data_in.out_kind = KIND_FINAL;
               // margin window compared on widened sums
               if (!in_data_ff.adc_ok) begin
                  out_data_in.status = ST_DEVERR;
               end else if (adc_plus < {1'b0, pend_mv_ff} ||
                            {1'b0, in_data_ff.adc_mv} > tgt_plus) begin
                  out_data_in.status = ST_DEVERR;
               end else begin
                  cached_in = {4'd0, pend_mv_ff};
                  out_data_in.status = ST_OK;
               end
            end else if (phase_ff == PH_DONE_EN) begin
               phase_in = PH_IDLE;
               out_data_in.out_kind = KIND_FINAL;
               out_data_in.status   = ST_OK;
            end
         end
         default: ;
      endcase

      out_data_in.voltage_mv   = cached_in;
      out_data_in.rail_enabled = enabled_in;
   end

   // input register, rail state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         cached_ff    <= 20'd0;
         enabled_ff   <= 1'b1;
         pend_mv_ff   <= 16'd0;
         pend_en_ff   <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
            in_data_ff  <= req_data;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            out_data_ff  <= out_data_in;
            phase_ff     <= phase_in;
            cached_ff    <= cached_in;
            enabled_ff   <= enabled_in;
            pend_mv_ff   <= pend_mv_in;
            pend_en_ff   <= pend_en_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// File: rtl/prs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_checker: port-level checks of the rail request sequencer
// Watches the response channel for stall stability and result consistency.
// ----------------------------------------------------------------------------
module prs_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  prs_pkg::prs_rsp_type  rsp_data
);
   import prs_pkg::*;

   // stalled response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // nothing comes out right after reset
   a_rsp_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // immediate replies carry no bus or alarm work
   a_reply_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_kind == KIND_REPLY |->
         rsp_data.write_len == LEN_NONE && rsp_data.read_len == LEN_NONE &&
         rsp_data.alarm_ms == 8'd0)
      else $error("immediate reply with command fields set");

   // pending only on commands that start further work
   a_pending_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_PENDING |->
         rsp_data.out_kind != KIND_REPLY && rsp_data.out_kind != KIND_FINAL)
      else $error("pending status on a closing response");

   // settling alarms are only armed on an enabled rail
   a_alarm_enabled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_kind == KIND_ALARM |-> rsp_data.rail_enabled)
      else $error("alarm started on a disabled rail");

endmodule

bind psu_rail_request_sequencer_unit prs_checker u_prs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: tb/prs_rail_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_rail_check_pkg: response scoreboard of the rail request sequencer
// Keeps its own copy of the rail state and the settings registers, works out
// the response of every accepted request and checks the block's responses
// against them in order.
// ----------------------------------------------------------------------------
package prs_rail_check_pkg;
   import prs_pkg::*;

   // Request type code that the block does not define
   localparam logic [2:0] REQ_UNDEF_LAST = 3'd7;

   // Voltage encoding: coarse 12.5 mV steps, fine 2.5 mV steps at bit 12
   localparam int unsigned UV_PER_MV = 1000;
   localparam int unsigned STEP_UV   = 2500;
   localparam int unsigned COARSE_UV = 5 * STEP_UV;
   localparam int unsigned FINE_MAX  = 7;
   localparam int unsigned FINE_POS  = 12;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_CONVERT,
      PH_WAIT_VOLT,
      PH_COMPARE,
      PH_WAIT_EN,
      PH_DONE_EN
   } rail_phase_type;

   class rail_response_scoreboard;
      // settings registers
      logic [1:0]  channel;
      logic [15:0] max_target;
      logic [7:0]  margin;
      logic [7:0]  ramp_set;
      logic [7:0]  ramp_enable;
      // rail state
      rail_phase_type ph;
      logic [19:0] cached_mv;
      logic        enabled;
      logic [19:0] pending_mv;
      logic        pending_enable;
      logic [15:0] pending_code;
      // responses still owed by the block, oldest first
      prs_rsp_type awaited[$];
      int unsigned errors;

      function new();
         channel        = RST_CHANNEL;
         max_target     = RST_MAX_TARGET;
         margin         = RST_MARGIN;
         ramp_set       = RST_RAMP_SET;
         ramp_enable    = RST_RAMP_EN;
         ph             = PH_IDLE;
         cached_mv      = '0;
         enabled        = 1'b1;
         pending_mv     = '0;
         pending_enable = 1'b0;
         pending_code   = '0;
         errors         = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] value);
         case (idx)
            CSR_CHANNEL:    channel     = value[1:0];
            CSR_MAX_TARGET: max_target  = value[15:0];
            CSR_MARGIN:     margin      = value[7:0];
            CSR_RAMP_SET:   ramp_set    = value[7:0];
            CSR_RAMP_EN:    ramp_enable = value[7:0];
            default: ;
         endcase
      endfunction

      // Compare a register read-back with the stored setting
      function void check_reg(logic [2:0] idx, logic [31:0] got);
         logic [31:0] want;
         case (idx)
            CSR_CHANNEL:    want = 32'(channel);
            CSR_MAX_TARGET: want = 32'(max_target);
            CSR_MARGIN:     want = 32'(margin);
            CSR_RAMP_SET:   want = 32'(ramp_set);
            CSR_RAMP_EN:    want = 32'(ramp_enable);
            default:        want = '0;
         endcase
         field_diff("register", want, got);
      endfunction

      // Advance the rail state by one request and queue the response it owes
      function void note_request(prs_req_type r);
         prs_rsp_type o;
         logic [31:0] tgt, adc, coarse, mvref, fine, scaled;
         o   = '0;
         tgt = 32'(r.target_mv);
         adc = 32'(r.adc_mv);
         case (r.req_type)
            REQ_SET_VOLT: begin
               // range is judged before busy
               if (tgt > 32'(max_target)) begin
                  o.out_kind = KIND_REPLY;
                  o.status   = ST_RANGE;
               end else if (ph != PH_IDLE) begin
                  o.out_kind = KIND_REPLY;
                  o.status   = ST_BUSY;
               end else if (cached_mv != '0 && 32'(cached_mv) == tgt) begin
                  o.out_kind = KIND_REPLY;
                  o.status   = ST_OK;
               end else begin
                  coarse = (tgt * UV_PER_MV) / COARSE_UV;
                  mvref  = (coarse * COARSE_UV) / UV_PER_MV;
                  fine   = ((tgt - mvref) * UV_PER_MV) / STEP_UV;
                  if (fine > FINE_MAX) fine = FINE_MAX;
                  pending_code = 16'((fine << FINE_POS) | coarse);
                  pending_mv   = 20'(tgt);
                  ph           = PH_WAIT_VOLT;
                  o.out_kind   = KIND_I2C_WRITE;
                  o.status     = ST_PENDING;
                  o.cmd_byte0  = CMD_SET_V + 8'(channel);
                  o.cmd_byte1  = pending_code[15:8];
                  o.cmd_byte2  = pending_code[7:0];
                  o.write_len  = LEN_THREE;
               end
            end
            REQ_GET_VOLT: begin
               if (ph != PH_IDLE) begin
                  o.out_kind = KIND_REPLY;
                  o.status   = ST_BUSY;
               end else if (cached_mv != '0) begin
                  o.out_kind = KIND_REPLY;
                  o.status   = ST_OK;
               end else begin
                  ph          = PH_CONVERT;
                  o.out_kind  = KIND_I2C_WR_RD;
                  o.status    = ST_PENDING;
                  o.cmd_byte0 = CMD_GET_V + 8'(channel);
                  o.write_len = LEN_ONE;
                  o.read_len  = LEN_TWO;
               end
            end
            REQ_SET_ENABLE: begin
               if (ph != PH_IDLE) begin
                  o.out_kind = KIND_REPLY;
                  o.status   = ST_BUSY;
               end else begin
                  pending_enable = r.enable_value;
                  ph             = PH_WAIT_EN;
                  o.out_kind     = KIND_I2C_WRITE;
                  o.status       = ST_PENDING;
                  o.cmd_byte0    = CMD_ENABLE;
                  o.cmd_byte1    = 8'(channel);
                  o.cmd_byte2    = 8'(r.enable_value);
                  o.write_len    = LEN_THREE;
               end
            end
            REQ_I2C_DONE: begin
               case (ph)
                  PH_CONVERT: begin
                     if (r.i2c_ok) begin
                        scaled    = 32'(r.read_word) * 32'(READ_SCALE);
                        cached_mv = scaled[19:0];
                     end
                     ph         = PH_IDLE;
                     o.out_kind = KIND_FINAL;
                     o.status   = r.i2c_ok ? ST_OK : ST_DEVERR;
                  end
                  PH_WAIT_VOLT: begin
                     if (!r.i2c_ok) begin
                        ph         = PH_IDLE;
                        o.out_kind = KIND_FINAL;
                        o.status   = ST_DEVERR;
                     end else if (enabled) begin
                        // live rail: settle, then compare against the ADC
                        ph         = PH_COMPARE;
                        o.out_kind = KIND_ALARM;
                        o.status   = ST_PENDING;
                        o.alarm_ms = ramp_set;
                     end else begin
                        cached_mv  = pending_mv;
                        ph         = PH_IDLE;
                        o.out_kind = KIND_FINAL;
                        o.status   = ST_OK;
                     end
                  end
                  PH_WAIT_EN: begin
                     if (!r.i2c_ok) begin
                        ph         = PH_IDLE;
                        o.out_kind = KIND_FINAL;
                        o.status   = ST_DEVERR;
                     end else begin
                        enabled = pending_enable;
                        if (enabled) begin
                           ph         = PH_DONE_EN;
                           o.out_kind = KIND_ALARM;
                           o.status   = ST_PENDING;
                           o.alarm_ms = ramp_enable;
                        end else begin
                           ph         = PH_IDLE;
                           o.out_kind = KIND_FINAL;
                           o.status   = ST_OK;
                        end
                     end
                  end
                  default: begin
                     o.out_kind = KIND_REPLY;
                     o.status   = ST_UNEXP;
                  end
               endcase
            end
            REQ_ALARM_DONE: begin
               case (ph)
                  PH_COMPARE: begin
                     // 32-bit sums, so neither side of the window wraps
                     if (!r.adc_ok) begin
                        o.status = ST_DEVERR;
                     end else if (adc + 32'(margin) < 32'(pending_mv) ||
                                  adc > 32'(pending_mv) + 32'(margin)) begin
                        o.status = ST_DEVERR;
                     end else begin
                        cached_mv = pending_mv;
                        o.status  = ST_OK;
                     end
                     ph         = PH_IDLE;
                     o.out_kind = KIND_FINAL;
                  end
                  PH_DONE_EN: begin
                     ph         = PH_IDLE;
                     o.out_kind = KIND_FINAL;
                     o.status   = ST_OK;
                  end
                  default: begin
                     o.out_kind = KIND_REPLY;
                     o.status   = ST_UNEXP;
                  end
               endcase
            end
            default: begin
               o.out_kind = KIND_REPLY;
               o.status   = ST_UNEXP;
            end
         endcase
         o.voltage_mv   = cached_mv;
         o.rail_enabled = enabled;
         awaited.push_back(o);
      endfunction

      function void field_diff(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         end
      endfunction

      // Compare one response from the block with the oldest one owed
      function void check_response(prs_rsp_type got);
         prs_rsp_type want;
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t: response with no request waiting, expected none actual %h",
                     $time, got);
            return;
         end
         want = awaited.pop_front();
         field_diff("out_kind",     32'(want.out_kind),     32'(got.out_kind));
         field_diff("status",       32'(want.status),       32'(got.status));
         field_diff("voltage_mv",   32'(want.voltage_mv),   32'(got.voltage_mv));
         field_diff("rail_enabled", 32'(want.rail_enabled), 32'(got.rail_enabled));
         field_diff("cmd_byte0",    32'(want.cmd_byte0),    32'(got.cmd_byte0));
         field_diff("cmd_byte1",    32'(want.cmd_byte1),    32'(got.cmd_byte1));
         field_diff("cmd_byte2",    32'(want.cmd_byte2),    32'(got.cmd_byte2));
         field_diff("write_len",    32'(want.write_len),    32'(got.write_len));
         field_diff("read_len",     32'(want.read_len),     32'(got.read_len));
         field_diff("alarm_ms",     32'(want.alarm_ms),     32'(got.alarm_ms));
      endfunction
   endclass

endpackage

// File: tb/psu_rail_request_sequencer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_rail_request_sequencer_unit_tb: testbench of the rail request sequencer
// A directed pass over the special cases, then mostly well-formed request and
// completion sequences with random content over several register settings,
// extremes included. Both sides idle at random; one long response stall
// backs the block up. Every response is checked field by field.
// ----------------------------------------------------------------------------
module psu_rail_request_sequencer_unit_tb;
   import prs_pkg::*;
   import prs_rail_check_pkg::*;

   localparam int RANDOM_PER_PHASE = 200;
   localparam int NUM_PHASES       = 8;
   localparam int HOLD_PHASE       = 3;
   localparam int RSP_HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT      = 2000;
   localparam int DRAIN_CYCLES     = 6;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   prs_req_type           req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   prs_rsp_type           rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   rail_response_scoreboard sb;

   bit tx_burst;
   bit rx_burst;
   bit rsp_hold_req;
   int rx_stall;
   int idle_cycles;

   psu_rail_request_sequencer_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Build one request from its fields
   function automatic prs_req_type mk(logic [2:0] kind, logic [15:0] tgt, logic en,
                                      logic ok, logic [15:0] word, logic aok,
                                      logic [15:0] adc);
      prs_req_type r;
      r.req_type     = kind;
      r.target_mv    = tgt;
      r.enable_value = en;
      r.i2c_ok       = ok;
      r.read_word    = word;
      r.adc_ok       = aok;
      r.adc_mv       = adc;
      return r;
   endfunction

   // Next random request: mostly the event the rail waits for, or a fresh
   // request when idle; some pure noise on every field
   function automatic prs_req_type next_request();
      prs_req_type r;
      int unsigned pick, span, lo, hi, mx;
      r = mk(3'($urandom_range(0, 7)), 16'($urandom), 1'($urandom), 1'($urandom),
             16'($urandom), 1'($urandom), 16'($urandom));
      pick = $urandom_range(0, 99);
      mx   = 32'(sb.max_target);
      if (pick < 12) return r;
      case (sb.ph)
         PH_CONVERT, PH_WAIT_VOLT, PH_WAIT_EN: begin
            r.req_type = REQ_I2C_DONE;
            r.i2c_ok   = ($urandom_range(0, 9) != 0);
            // a zero read leaves the cache unknown again
            if ($urandom_range(0, 3) == 0) r.read_word = 16'($urandom_range(0, 3));
         end
         PH_COMPARE: begin
            r.req_type = REQ_ALARM_DONE;
            r.adc_ok   = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 4) != 0) begin
               // land around the edges of the margin window
               span = 32'(sb.margin) + 3;
               lo   = (32'(sb.pending_mv) > span) ? 32'(sb.pending_mv) - span : 0;
               hi   = 32'(sb.pending_mv) + span;
               if (hi > 65535) hi = 65535;
               r.adc_mv = 16'($urandom_range(lo, hi));
            end
         end
         PH_DONE_EN: begin
            r.req_type = REQ_ALARM_DONE;
         end
         default: begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               r.req_type = REQ_SET_VOLT;
               case ($urandom_range(0, 9))
                  0: r.target_mv = (mx < 65535) ? 16'($urandom_range(mx + 1, 65535))
                                                : 16'hFFFF;
                  1: r.target_mv = '0;
                  2: r.target_mv = (sb.cached_mv != '0 && sb.cached_mv <= 20'hFFFF) ?
                                   sb.cached_mv[15:0] : 16'($urandom_range(0, mx));
                  3: r.target_mv = sb.max_target;
                  default: r.target_mv = 16'($urandom_range(0, mx));
               endcase
            end else if (pick < 70) begin
               r.req_type = REQ_GET_VOLT;
            end else begin
               r.req_type     = REQ_SET_ENABLE;
               r.enable_value = ($urandom_range(0, 3) != 0);
            end
         end
      endcase
      return r;
   endfunction

   // Offer one request after a random gap and hold it until taken
   task automatic send_request(input prs_req_type r);
      int unsigned gap;
      if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
      gap = tx_burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      @(negedge clock);
   endtask

   // Stop offering and wait until every owed response is back
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write (setup cycle, then access cycle), then a read-back
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_reg(idx, value);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.check_reg(idx, prdata);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Response side: random stalls, bursts without stalls, one long hold-off
   initial begin
      rsp_ready = 1'b0;
      forever begin
         if (rsp_hold_req) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            rsp_hold_req = 1'b0;
         end
         if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
         rx_stall = rx_burst ? 0 : $urandom_range(0, 8);
         if (rx_stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (rx_stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Response check and watchdog on cycles with no transfer at all
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[psu_rail_request_sequencer_unit] ERROR");
            $finish;
         end
      end
   end

   // Main sequence
   initial begin
      int p, i;
      logic [1:0]  ch;
      logic [15:0] mx;
      logic [7:0]  mg, rs, re;
      sb           = new();
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      tx_burst     = 1'b0;
      rx_burst     = 1'b0;
      rsp_hold_req = 1'b0;
      idle_cycles  = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // events out of place and undefined request types
      send_request(mk(REQ_UNDEF_LAST, 0, 0, 0, 0, 0, 0));
      send_request(mk(REQ_I2C_DONE, 0, 0, 1, 0, 0, 0));
      send_request(mk(REQ_ALARM_DONE, 0, 0, 0, 0, 1, 0));
      // busy while a read is open; range wins over busy; failed read
      send_request(mk(REQ_GET_VOLT, 0, 0, 0, 0, 0, 0));
      send_request(mk(REQ_GET_VOLT, 0, 0, 0, 0, 0, 0));
      send_request(mk(REQ_SET_VOLT, 1101, 0, 0, 0, 0, 0));
      send_request(mk(REQ_SET_VOLT, 1100, 0, 0, 0, 0, 0));
      send_request(mk(REQ_I2C_DONE, 0, 0, 0, 0, 0, 0));
      // read-back of the largest word, then answered from the cache
      send_request(mk(REQ_GET_VOLT, 0, 0, 0, 0, 0, 0));
      send_request(mk(REQ_I2C_DONE, 0, 0, 1, 16'hFFFF, 0, 0));
      send_request(mk(REQ_GET_VOLT, 0, 0, 0, 0, 0, 0));
      // set at the maximum, ADC reading invalid
      send_request(mk(REQ_SET_VOLT, 1100, 0, 0, 0, 0, 0));
      send_request(mk(REQ_I2C_DONE, 0, 0, 1, 0, 0, 0));
      send_request(mk(REQ_ALARM_DONE, 0, 0, 0, 0, 0, 16'hFFFF));
      // ADC exactly at the low edge of the window
      send_request(mk(REQ_SET_VOLT, 1087, 0, 0, 0, 0, 0));
      send_request(mk(REQ_I2C_DONE, 0, 0, 1, 0, 0, 0));
      send_request(mk(REQ_ALARM_DONE, 0, 0, 0, 0, 1, 1067));
      // same target as the cache
      send_request(mk(REQ_SET_VOLT, 1087, 0, 0, 0, 0, 0));
      // ADC one above the window
      send_request(mk(REQ_SET_VOLT, 1000, 0, 0, 0, 0, 0));
      send_request(mk(REQ_I2C_DONE, 0, 0, 1, 0, 0, 0));
      send_request(mk(REQ_ALARM_DONE, 0, 0, 0, 0, 1, 1021));
      // disable, set without a compare, enable again
      send_request(mk(REQ_SET_ENABLE, 0, 0, 0, 0, 0, 0));
      send_request(mk(REQ_I2C_DONE, 0, 0, 1, 0, 0, 0));
      send_request(mk(REQ_SET_VOLT, 0, 0, 0, 0, 0, 0));
      send_request(mk(REQ_I2C_DONE, 0, 0, 1, 0, 0, 0));
      send_request(mk(REQ_SET_ENABLE, 0, 1, 0, 0, 0, 0));
      send_request(mk(REQ_I2C_DONE, 0, 0, 1, 0, 0, 0));
      send_request(mk(REQ_ALARM_DONE, 0, 0, 0, 0, 0, 0));

      for (p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) begin
            drain_responses();
            case (p)
               1: begin
                  ch = 2'd3;  mx = 16'hFFFF; mg = 8'hFF; rs = 8'hFF; re = 8'hFF;
               end
               2: begin
                  ch = 2'd0;  mx = 16'h0000; mg = 8'h00; rs = 8'h00; re = 8'h00;
               end
               default: begin
                  ch = 2'($urandom_range(0, 3));
                  mx = $urandom_range(0, 1) ? 16'($urandom_range(500, 5000))
                                            : 16'($urandom);
                  mg = 8'($urandom);
                  rs = 8'($urandom);
                  re = 8'($urandom);
               end
            endcase
            csr_write(CSR_CHANNEL,    32'(ch));
            csr_write(CSR_MAX_TARGET, 32'(mx));
            csr_write(CSR_MARGIN,     32'(mg));
            csr_write(CSR_RAMP_SET,   32'(rs));
            csr_write(CSR_RAMP_EN,    32'(re));
         end
         if (p == 1) begin
            // close whatever sequence is open, then sums that would wrap 16 bits
            while (sb.ph != PH_IDLE)
               send_request(mk((sb.ph == PH_COMPARE || sb.ph == PH_DONE_EN) ?
                               REQ_ALARM_DONE : REQ_I2C_DONE, 0, 0, 0, 0, 0, 0));
            send_request(mk(REQ_SET_ENABLE, 0, 1, 0, 0, 0, 0));
            send_request(mk(REQ_I2C_DONE, 0, 0, 1, 0, 0, 0));
            send_request(mk(REQ_ALARM_DONE, 0, 0, 0, 0, 0, 0));
            send_request(mk(REQ_SET_VOLT, 16'hFFFF, 0, 0, 0, 0, 0));
            send_request(mk(REQ_I2C_DONE, 0, 0, 1, 0, 0, 0));
            send_request(mk(REQ_ALARM_DONE, 0, 0, 0, 0, 1, 16'hFFFF));
            send_request(mk(REQ_SET_VOLT, 300, 0, 0, 0, 0, 0));
            send_request(mk(REQ_I2C_DONE, 0, 0, 1, 0, 0, 0));
            send_request(mk(REQ_ALARM_DONE, 0, 0, 0, 0, 1, 16'hFFFF));
            send_request(mk(REQ_SET_VOLT, 100, 0, 0, 0, 0, 0));
            send_request(mk(REQ_I2C_DONE, 0, 0, 1, 0, 0, 0));
            send_request(mk(REQ_ALARM_DONE, 0, 0, 0, 0, 1, 0));
         end
         for (i = 0; i < RANDOM_PER_PHASE; i++) begin
            if (p == HOLD_PHASE && i == 50) rsp_hold_req = 1'b1;
            send_request(next_request());
         end
      end

      drain_responses();
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("[psu_rail_request_sequencer_unit] OK");
      end else begin
         $display("[psu_rail_request_sequencer_unit] ERROR");
      end
      $finish;
   end

endmodule
